// ----- rtl/core/ssaa_pkg.sv -----
package ssaa_pkg;

	// Configuration port
	localparam int DIM_W      = 11;
	localparam int SCALE_W    = 4;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LOW_RES_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_RES_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SSAA_SCALE     = 2'd2;

	localparam logic [DIM_W-1:0]   WIDTH_RESET  = 11'd640;
	localparam logic [DIM_W-1:0]   HEIGHT_RESET = 11'd480;
	localparam logic [SCALE_W-1:0] SCALE_RESET  = 4'd4;

	// Field widths
	localparam int COLOUR_W = 8;
	localparam int DEPTH_W  = 32;
	localparam int XY_W     = 10;
	localparam int ROW_W    = 10;

	localparam int MAX_LOW_HEIGHT = 1024;

	typedef struct packed {
		logic                frame_start;
		logic [COLOUR_W-1:0] in_red;
		logic [COLOUR_W-1:0] in_green;
		logic [COLOUR_W-1:0] in_blue;
		logic [DEPTH_W-1:0]  in_depth_bits;
	} sample_t;

	typedef struct packed {
		logic [XY_W-1:0]     out_x;
		logic [XY_W-1:0]     out_y;
		logic [COLOUR_W-1:0] out_red;
		logic [COLOUR_W-1:0] out_green;
		logic [COLOUR_W-1:0] out_blue;
		logic [DEPTH_W-1:0]  out_depth_bits;
		logic                frame_done;
	} pixel_t;

	// Position of one sample within its block, worked out at acceptance.
	typedef struct packed {
		logic            first;
		logic            centre;
		logic            last;
		logic            done;
		logic [XY_W-1:0] x;
		logic [XY_W-1:0] y;
	} blk_ctrl_t;

endpackage

// ----- rtl/core/ssaa_if.sv -----
interface ssaa_sample_if import ssaa_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ssaa_pixel_if import ssaa_pkg::*;;
	logic   valid;
	logic   ready;
	pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/ssaa_col_store.sv -----
module ssaa_col_store import ssaa_pkg::*; #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int SUM_W  = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                take,
	input  logic [ADDR_W-1:0]   addr,
	input  logic [COLOUR_W-1:0] red,
	input  logic [COLOUR_W-1:0] green,
	input  logic [COLOUR_W-1:0] blue,
	input  logic [DEPTH_W-1:0]  depth,
	input  blk_ctrl_t           ctrl,
	output logic                res_valid,
	output logic [SUM_W-1:0]    res_red,
	output logic [SUM_W-1:0]    res_green,
	output logic [SUM_W-1:0]    res_blue,
	output logic [DEPTH_W-1:0]  res_depth,
	output blk_ctrl_t           res_ctrl
);

	localparam int ENT_W = 3*SUM_W + DEPTH_W;

	// One entry per low-res column: {red, green, blue, centre depth}.
	logic [ENT_W-1:0] mem [DEPTH];

	logic [ENT_W-1:0]    rd_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [COLOUR_W-1:0] red_s1, green_s1, blue_s1;
	logic [DEPTH_W-1:0]  depth_s1;
	blk_ctrl_t           ctrl_s1;
	logic                valid_s1;

	logic [ENT_W-1:0]  fwd_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic              fwd_valid_q;

	logic [ENT_W-1:0]   old_ent, new_ent;
	logic [SUM_W-1:0]   old_red, old_green, old_blue;
	logic [SUM_W-1:0]   new_red, new_green, new_blue;
	logic [DEPTH_W-1:0] old_depth, new_depth;

	logic [SUM_W-1:0]   red_s2, green_s2, blue_s2;
	logic [DEPTH_W-1:0] depth_s2;
	blk_ctrl_t          ctrl_s2;
	logic               valid_s2;

	// The read for the next request happens on the same edge as this write, so
	// a request for the same column picks up the value just written instead.
	always_comb begin
		old_ent = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_q : rd_s1;
		{old_red, old_green, old_blue, old_depth} = old_ent;
		new_red   = ctrl_s1.first ? SUM_W'(red_s1)   : old_red   + SUM_W'(red_s1);
		new_green = ctrl_s1.first ? SUM_W'(green_s1) : old_green + SUM_W'(green_s1);
		new_blue  = ctrl_s1.first ? SUM_W'(blue_s1)  : old_blue  + SUM_W'(blue_s1);
		new_depth = ctrl_s1.centre ? depth_s1 : old_depth;
		new_ent   = {new_red, new_green, new_blue, new_depth};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (take) begin
				rd_s1 <= mem[addr];
			end
			if (valid_s1) begin
				mem[addr_s1] <= new_ent;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && take) begin
			addr_s1  <= addr;
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			depth_s1 <= depth;
			ctrl_s1  <= ctrl;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			fwd_q      <= new_ent;
			fwd_addr_q <= addr_s1;
		end
		if (en && valid_s1 && ctrl_s1.last) begin
			red_s2   <= new_red;
			green_s2 <= new_green;
			blue_s2  <= new_blue;
			depth_s2 <= new_depth;
			ctrl_s2  <= ctrl_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			valid_s2    <= 1'b0;
		end else if (en) begin
			valid_s1 <= take;
			valid_s2 <= valid_s1 && ctrl_s1.last;
			if (valid_s1) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	assign res_valid = valid_s2;
	assign res_red   = red_s2;
	assign res_green = green_s2;
	assign res_blue  = blue_s2;
	assign res_depth = depth_s2;
	assign res_ctrl  = ctrl_s2;

endmodule

// ----- rtl/core/ssaa_avg.sv -----
module ssaa_avg import ssaa_pkg::*; #(
	parameter int MAX_SCALE = 8,
	parameter int SUM_W     = 14,
	parameter int S_W       = 4
) (
	input  logic                clk,
	input  logic                en,
	input  logic                load,
	input  logic [S_W-1:0]      scale,
	input  logic [SUM_W-1:0]    sum_red,
	input  logic [SUM_W-1:0]    sum_green,
	input  logic [SUM_W-1:0]    sum_blue,
	output logic [COLOUR_W-1:0] avg_red,
	output logic [COLOUR_W-1:0] avg_green,
	output logic [COLOUR_W-1:0] avg_blue
);

	// Division by scale squared as a multiply by a rounded-up reciprocal. With
	// the shift at sum bits plus area bits the quotient is exact for every sum.
	localparam int AREA_BITS = SUM_W - COLOUR_W;
	localparam int K         = SUM_W + AREA_BITS;
	localparam int RECIP_W   = K + 1;
	localparam int PROD_W    = SUM_W + RECIP_W;

	logic [RECIP_W-1:0] recip_tab [MAX_SCALE+1];
	logic [RECIP_W-1:0] recip;
	logic [PROD_W-1:0]  prod_red_q, prod_green_q, prod_blue_q;

	assign recip_tab[0] = '0;

	for (genvar i = 1; i <= MAX_SCALE; i++) begin : g_recip
		localparam longint unsigned Area  = longint'(i) * longint'(i);
		localparam longint unsigned Recip = ((64'd1 << K) + Area - 64'd1) / Area;
		assign recip_tab[i] = RECIP_W'(Recip);
	end

	assign recip = recip_tab[scale];

	always_ff @(posedge clk) begin
		if (en && load) begin
			prod_red_q   <= PROD_W'(sum_red)   * PROD_W'(recip);
			prod_green_q <= PROD_W'(sum_green) * PROD_W'(recip);
			prod_blue_q  <= PROD_W'(sum_blue)  * PROD_W'(recip);
		end
	end

	assign avg_red   = prod_red_q[K +: COLOUR_W];
	assign avg_green = prod_green_q[K +: COLOUR_W];
	assign avg_blue  = prod_blue_q[K +: COLOUR_W];

endmodule

// ----- rtl/core/ssaa_box_downsampler.sv -----
// A block's pixel passes the line-memory read and result stages and the output
// register once its last sample is taken. Throughput: one sample per cycle
// while the result side keeps up, set by the column line memory, which is read
// and written once per sample with the latest write forwarded to the next
// request. Reset clears the position counters and loads the register defaults
// (640 by 480, scale 4); the line memory is not cleared and needs no pass.
module ssaa_box_downsampler import ssaa_pkg::*; #(
	parameter int MAX_LOW_WIDTH = 1024,
	parameter int MAX_SCALE     = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	ssaa_sample_if.sink          samples,
	ssaa_pixel_if.source         pixels
);

	localparam int COL_W     = $clog2(MAX_LOW_WIDTH);
	localparam int W_W       = $clog2(MAX_LOW_WIDTH + 1);
	localparam int SUB_W     = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
	localparam int S_W       = $clog2(MAX_SCALE + 1);
	localparam int AREA_BITS = $clog2(MAX_SCALE * MAX_SCALE);
	localparam int SUM_W     = COLOUR_W + AREA_BITS;

	logic [DIM_W-1:0]   width_q, height_q;
	logic [SCALE_W-1:0] scale_q;

	logic [W_W-1:0]   w_c, w_last;
	logic [DIM_W-1:0] h_c, h_last;
	logic [S_W-1:0]   s_c, s_last, half;

	logic [COL_W-1:0] col_q, col_cur, col_n;
	logic [SUB_W-1:0] sub_col_q, sc_cur, sc_n;
	logic [SUB_W-1:0] sub_row_q, sr_cur, sr_n;
	logic [ROW_W-1:0] row_q, row_cur, row_n;
	logic [COL_W:0]   col_inc;
	logic [SUB_W:0]   sc_inc, sr_inc;
	logic [ROW_W:0]   row_inc;
	logic [COL_W+XY_W-1:0] col_ext;

	logic      en, take;
	blk_ctrl_t ctrl;

	logic               res_valid;
	logic [SUM_W-1:0]   res_red, res_green, res_blue;
	logic [DEPTH_W-1:0] res_depth;
	blk_ctrl_t          res_ctrl;

	logic [COLOUR_W-1:0] avg_red, avg_green, avg_blue;
	logic                out_valid_q;
	logic [XY_W-1:0]     out_x_q, out_y_q;
	logic [DEPTH_W-1:0]  out_depth_q;
	logic                frame_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			scale_q  <= SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOW_RES_WIDTH:  width_q  <= cfg_data;
				CFG_LOW_RES_HEIGHT: height_q <= cfg_data;
				CFG_SSAA_SCALE:     scale_q  <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero acts as one; anything above the supported maximum saturates.
	always_comb begin
		if (width_q == '0) begin
			w_c = W_W'(1);
		end else if (32'(width_q) > 32'(MAX_LOW_WIDTH)) begin
			w_c = W_W'(MAX_LOW_WIDTH);
		end else begin
			w_c = W_W'(width_q);
		end
		if (height_q == '0) begin
			h_c = DIM_W'(1);
		end else if (32'(height_q) > 32'(MAX_LOW_HEIGHT)) begin
			h_c = DIM_W'(MAX_LOW_HEIGHT);
		end else begin
			h_c = height_q;
		end
		if (scale_q == '0) begin
			s_c = S_W'(1);
		end else if (32'(scale_q) > 32'(MAX_SCALE)) begin
			s_c = S_W'(MAX_SCALE);
		end else begin
			s_c = S_W'(scale_q);
		end
		w_last = w_c - 1'b1;
		h_last = h_c - 1'b1;
		s_last = s_c - 1'b1;
		half   = s_c >> 1;
	end

	assign en            = !out_valid_q || pixels.ready;
	assign samples.ready = en;
	assign take          = samples.valid && en;

	always_comb begin
		if (samples.data.frame_start) begin
			col_cur = '0;
			sc_cur  = '0;
			sr_cur  = '0;
			row_cur = '0;
		end else begin
			col_cur = col_q;
			sc_cur  = sub_col_q;
			sr_cur  = sub_row_q;
			row_cur = row_q;
		end

		col_ext     = (COL_W+XY_W)'(col_cur);
		ctrl.first  = (sc_cur == '0) && (sr_cur == '0);
		ctrl.centre = (sc_cur == half) && (sr_cur == half);
		ctrl.last   = (sc_cur == s_last) && (sr_cur == s_last);
		ctrl.done   = (col_cur == w_last) && (row_cur == h_last);
		ctrl.x      = col_ext[XY_W-1:0];
		ctrl.y      = row_cur;

		// Raster advance: sub-column, column, sub-row, row, each wrapping on
		// reaching its bound (or beyond it after a register change).
		sc_inc  = {1'b0, sc_cur} + 1'b1;
		col_inc = {1'b0, col_cur} + 1'b1;
		sr_inc  = {1'b0, sr_cur} + 1'b1;
		row_inc = {1'b0, row_cur} + 1'b1;
		sc_n    = sc_cur;
		col_n   = col_cur;
		sr_n    = sr_cur;
		row_n   = row_cur;
		if (sc_inc >= s_c) begin
			sc_n = '0;
			if (col_inc >= w_c) begin
				col_n = '0;
				if (sr_inc >= s_c) begin
					sr_n = '0;
					if (row_inc >= h_c) begin
						row_n = '0;
					end else begin
						row_n = row_inc[ROW_W-1:0];
					end
				end else begin
					sr_n = sr_inc[SUB_W-1:0];
				end
			end else begin
				col_n = col_inc[COL_W-1:0];
			end
		end else begin
			sc_n = sc_inc[SUB_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			sub_col_q <= '0;
			sub_row_q <= '0;
			row_q     <= '0;
		end else if (take) begin
			col_q     <= col_n;
			sub_col_q <= sc_n;
			sub_row_q <= sr_n;
			row_q     <= row_n;
		end
	end

	ssaa_col_store #(
		.DEPTH  (MAX_LOW_WIDTH),
		.ADDR_W (COL_W),
		.SUM_W  (SUM_W)
	) u_col_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.take      (take),
		.addr      (col_cur),
		.red       (samples.data.in_red),
		.green     (samples.data.in_green),
		.blue      (samples.data.in_blue),
		.depth     (samples.data.in_depth_bits),
		.ctrl      (ctrl),
		.res_valid (res_valid),
		.res_red   (res_red),
		.res_green (res_green),
		.res_blue  (res_blue),
		.res_depth (res_depth),
		.res_ctrl  (res_ctrl)
	);

	ssaa_avg #(
		.MAX_SCALE (MAX_SCALE),
		.SUM_W     (SUM_W),
		.S_W       (S_W)
	) u_avg (
		.clk       (clk),
		.en        (en),
		.load      (res_valid),
		.scale     (s_c),
		.sum_red   (res_red),
		.sum_green (res_green),
		.sum_blue  (res_blue),
		.avg_red   (avg_red),
		.avg_green (avg_green),
		.avg_blue  (avg_blue)
	);

	always_ff @(posedge clk) begin
		if (en && res_valid) begin
			out_x_q      <= res_ctrl.x;
			out_y_q      <= res_ctrl.y;
			out_depth_q  <= res_depth;
			frame_done_q <= res_ctrl.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= res_valid;
		end
	end

	assign pixels.valid = out_valid_q;
	assign pixels.data  = {out_x_q, out_y_q, avg_red, avg_green, avg_blue,
		out_depth_q, frame_done_q};

	// The sample side only stalls behind a result that is waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> pixels.valid)
		else $error("sample side stalled with no result waiting");

	// A result only appears after a block's last sample has left the line memory.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pixels.valid) |-> $past(res_valid))
		else $error("result presented without a completed block");

	// A frame start restarts the raster at the second sample of the first block.
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && samples.data.frame_start && s_c > S_W'(1)) |=>
		(col_q == '0 && sub_row_q == '0 && row_q == '0 && sub_col_q == SUB_W'(1)))
		else $error("position counters not restarted by frame start");

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ssaa_pkg::*;

	localparam int LINE_DEPTH   = 1024;
	localparam int SCALE_LIMIT  = 8;
	localparam int LATENCY      = 2;
	localparam int SETTLE       = LATENCY + 3;
	localparam int RANDOM_ITEMS = 900;
	localparam int DRAIN_LIMIT  = 20000;

	// Index 3 is not a register; writes to it must leave the block unchanged.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	ssaa_sample_if sample_ch ();
	ssaa_pixel_if  pixel_ch ();

	ssaa_box_downsampler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (sample_ch),
		.pixels    (pixel_ch)
	);

	// Register copies and raster position of the predictor.
	logic [DIM_W-1:0]   reg_width;
	logic [DIM_W-1:0]   reg_height;
	logic [SCALE_W-1:0] reg_scale;
	int unsigned        col_pos;
	int unsigned        row_pos;
	int unsigned        sub_x;
	int unsigned        sub_y;

	int unsigned        red_line [LINE_DEPTH];
	int unsigned        green_line [LINE_DEPTH];
	int unsigned        blue_line [LINE_DEPTH];
	bit [DEPTH_W-1:0]   depth_line [LINE_DEPTH];

	pixel_t             pending_pixels [$];

	bit                 src_idle;
	bit                 snk_idle;
	int unsigned        n_samples;
	int unsigned        n_pixels;
	int unsigned        n_settings;
	int unsigned        n_errors;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	// Box-filter resolve of one accepted sample; queues the low-res pixel it completes.
	function automatic void resolve_sample(input sample_t smp);
		int unsigned w;
		int unsigned h;
		int unsigned s;
		int unsigned half;
		int unsigned x;
		int unsigned area;
		pixel_t      px;
		w = clamp_dim(reg_width, LINE_DEPTH);
		h = clamp_dim(reg_height, MAX_LOW_HEIGHT);
		s = clamp_dim(reg_scale, SCALE_LIMIT);
		half = s / 2;
		if (smp.frame_start) begin
			col_pos = 0;
			row_pos = 0;
			sub_x = 0;
			sub_y = 0;
		end
		x = col_pos % LINE_DEPTH;
		if (sub_x == 0 && sub_y == 0) begin
			red_line[x] = smp.in_red;
			green_line[x] = smp.in_green;
			blue_line[x] = smp.in_blue;
		end else begin
			red_line[x] += smp.in_red;
			green_line[x] += smp.in_green;
			blue_line[x] += smp.in_blue;
		end
		if (sub_x == half && sub_y == half)
			depth_line[x] = smp.in_depth_bits;
		if (sub_x == s - 1 && sub_y == s - 1) begin
			area = s * s;
			px.out_x = XY_W'(col_pos);
			px.out_y = XY_W'(row_pos);
			px.out_red = COLOUR_W'(red_line[x] / area);
			px.out_green = COLOUR_W'(green_line[x] / area);
			px.out_blue = COLOUR_W'(blue_line[x] / area);
			px.out_depth_bits = depth_line[x];
			px.frame_done = (col_pos == w - 1 && row_pos == h - 1);
			pending_pixels = {pending_pixels, px};
		end
		sub_x++;
		if (sub_x >= s) begin
			sub_x = 0;
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				sub_y++;
				if (sub_y >= s) begin
					sub_y = 0;
					row_pos++;
					if (row_pos >= h)
						row_pos = 0;
				end
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		n_errors++;
	endtask

	task automatic check_pixel(input pixel_t got);
		pixel_t want;
		n_pixels++;
		if (pending_pixels.size() == 0) begin
			report_mismatch("pixel with none pending, x", got.out_x, 0);
		end else begin
			want = pending_pixels.pop_front();
			if (got.out_x !== want.out_x)
				report_mismatch("out_x", got.out_x, want.out_x);
			if (got.out_y !== want.out_y)
				report_mismatch("out_y", got.out_y, want.out_y);
			if (got.out_red !== want.out_red)
				report_mismatch("out_red", got.out_red, want.out_red);
			if (got.out_green !== want.out_green)
				report_mismatch("out_green", got.out_green, want.out_green);
			if (got.out_blue !== want.out_blue)
				report_mismatch("out_blue", got.out_blue, want.out_blue);
			if (got.out_depth_bits !== want.out_depth_bits)
				report_mismatch("out_depth_bits", got.out_depth_bits, want.out_depth_bits);
			if (got.frame_done !== want.frame_done)
				report_mismatch("frame_done", got.frame_done, want.frame_done);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1)
			check_pixel(pixel_ch.data);
	end

	initial begin : pixel_sink
		int unsigned gap;
		pixel_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = snk_idle ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				pixel_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pixel_ch.ready <= 1'b1;
			do @(posedge clk); while (pixel_ch.valid !== 1'b1);
		end
	end

	function automatic logic [COLOUR_W-1:0] pick_colour();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return COLOUR_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic sample_t random_sample(input bit fs);
		sample_t smp;
		smp.frame_start = fs;
		smp.in_red = pick_colour();
		smp.in_green = pick_colour();
		smp.in_blue = pick_colour();
		smp.in_depth_bits = $urandom;
		return smp;
	endfunction

	function automatic sample_t make_sample(input bit fs, input logic [COLOUR_W-1:0] r,
			input logic [COLOUR_W-1:0] g, input logic [COLOUR_W-1:0] b,
			input logic [DEPTH_W-1:0] d);
		sample_t smp;
		smp.frame_start = fs;
		smp.in_red = r;
		smp.in_green = g;
		smp.in_blue = b;
		smp.in_depth_bits = d;
		return smp;
	endfunction

	// Called just after a rising edge; returns at the edge where the request is taken.
	task automatic send_sample(input sample_t smp);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.data <= smp;
		sample_ch.valid <= 1'b1;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		resolve_sample(smp);
		n_samples++;
	endtask

	task automatic send_frame(input int unsigned count, input bit with_start);
		int unsigned i;
		for (i = 0; i < count; i++)
			send_sample(random_sample(with_start && i == 0));
	endtask

	// Stops the sample stream and waits, under a guard, until no pixel is pending.
	task automatic drain();
		int unsigned guard;
		sample_ch.valid <= 1'b0;
		for (guard = 0; guard < DRAIN_LIMIT && pending_pixels.size() != 0; guard++)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input logic [DIM_W-1:0] sc);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_LOW_RES_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= CFG_LOW_RES_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_index <= CFG_SSAA_SCALE;
		cfg_data <= sc;
		@(posedge clk);
		cfg_index <= CFG_UNUSED;
		cfg_data <= DIM_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_width = w;
		reg_height = h;
		reg_scale = sc[SCALE_W-1:0];
		n_settings++;
	endtask

	task automatic test_scale_one();
		apply_settings(11'd2, 11'd2, 11'd1);
		send_sample(make_sample(1'b1, 8'h00, 8'h00, 8'h00, 32'h0000_0000));
		send_sample(make_sample(1'b0, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
		send_sample(make_sample(1'b0, 8'h55, 8'hAA, 8'h0F, 32'h8000_0000));
		send_sample(make_sample(1'b0, 8'hAA, 8'h55, 8'hF0, 32'h7FFF_FFFF));
	endtask

	// Zero in every register acts as one, so each sample is a whole frame.
	task automatic test_zero_registers();
		apply_settings(11'd0, 11'd0, 11'd0);
		send_sample(random_sample(1'b1));
		send_sample(random_sample(1'b0));
	endtask

	task automatic test_frame_restart();
		int i;
		apply_settings(11'd1, 11'd1, 11'd2);
		send_sample(random_sample(1'b1));
		for (i = 0; i < 4; i++)
			send_sample(make_sample(i == 0, 8'hFF, 8'hFF, 8'hFF, 32'h3F80_0000 + i));
	endtask

	// Registers shrink while the position lies past the new bounds. Every line
	// entry touched here has been written by an earlier complete frame.
	task automatic test_counter_overrun();
		int i;
		apply_settings(11'd4, 11'd1, 11'd1);
		for (i = 0; i < 7; i++)
			send_sample(random_sample(i == 0));
		apply_settings(11'd2, 11'd1, 11'd1);
		send_sample(random_sample(1'b0));
		send_sample(random_sample(1'b1));
		apply_settings(11'd1, 11'd1, 11'd2);
		for (i = 0; i < 3; i++)
			send_sample(random_sample(i == 0));
		apply_settings(11'd1, 11'd1, 11'd1);
		send_sample(random_sample(1'b0));
		send_sample(random_sample(1'b0));
	endtask

	task automatic test_random_frames();
		int unsigned first;
		int unsigned w;
		int unsigned h;
		int unsigned s;
		int unsigned sc_raw;
		int unsigned size;
		int unsigned cut;
		bit          restart;
		first = n_samples;
		while (n_samples - first < RANDOM_ITEMS) begin
			sc_raw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
			s = clamp_dim(sc_raw, SCALE_LIMIT);
			w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, (s > 4) ? 1 : 6);
			h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, (s > 4) ? 2 : 4);
			src_idle = ($urandom_range(0, 3) != 0);
			snk_idle = ($urandom_range(0, 3) != 0);
			apply_settings(DIM_W'(w), DIM_W'(h), {7'($urandom_range(0, 127)), SCALE_W'(sc_raw)});
			size = clamp_dim(w, LINE_DEPTH) * clamp_dim(h, MAX_LOW_HEIGHT) * s * s;
			// A cut-short frame must be followed by one that starts afresh.
			restart = 1'b1;
			repeat ($urandom_range(1, 3)) begin
				cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, size) : size;
				send_frame(cut, restart || $urandom_range(0, 1));
				restart = (cut < size);
			end
		end
	endtask

	task automatic test_widest_line();
		src_idle = ($urandom_range(0, 1) != 0);
		snk_idle = ($urandom_range(0, 1) != 0);
		apply_settings(11'h7FF, 11'd1, 11'd1);
		send_frame(LINE_DEPTH, 1'b1);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_LOW_RES_WIDTH;
		cfg_data <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.data <= '0;
		reg_width = WIDTH_RESET;
		reg_height = HEIGHT_RESET;
		reg_scale = SCALE_RESET;
		col_pos = 0;
		row_pos = 0;
		sub_x = 0;
		sub_y = 0;
		src_idle = 1'b1;
		snk_idle = 1'b1;
		n_samples = 0;
		n_pixels = 0;
		n_settings = 0;
		n_errors = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_scale_one();
		test_zero_registers();
		test_frame_restart();
		test_counter_overrun();
		test_random_frames();
		test_widest_line();

		drain();
		if (pending_pixels.size() != 0)
			report_mismatch("pixels never delivered", pending_pixels.size(), 0);
		$display("Resolved %0d high-res samples into %0d low-res pixels", n_samples, n_pixels);
		$display("under %0d register settings, extremes and mid-frame changes included.",
			n_settings);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
